### hdl/assert_macros.svh
// Assertion macros for the heap queue RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/fahq_pkg.sv
// Package: constants, types and key compare for the 4-ary heap queue
`default_nettype none
package fahq_pkg;
    localparam int CAPACITY   = 1024;
    localparam int ARITY_LOG  = 2;
    localparam int ARITY      = 1 << ARITY_LOG;
    localparam int DIST_BITS  = 32;
    localparam int NODE_BITS  = 10;
    localparam int NODE_SPACE = 1 << NODE_BITS;
    localparam int HOP_BITS   = 16;
    localparam int SLOT_BITS  = $clog2(CAPACITY);
    localparam int CNT_BITS   = SLOT_BITS + 1;
    localparam int KID_BITS   = (ARITY_LOG > 0) ? ARITY_LOG : 1;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_INSERT  = 2'd1;
    localparam logic [1:0] OP_EXTRACT = 2'd2;

    typedef struct packed {
        logic [NODE_BITS-1:0] node;
        logic [DIST_BITS-1:0] distance;
        logic [HOP_BITS-1:0]  hops;
    } t_entry;

    // Controller commands to the datapath
    typedef struct packed {
        logic latch_in;     // capture input item, clear results
        logic clear_map;    // bump map epoch (clear)
        logic sweep;        // write one map entry as not in heap, step sweep address
        logic set_count1;
        logic inc_count;
        logic dec_count;
        logic rd_map;       // read position map at item node
        logic up_init_pos;  // pos <= map slot (decrease) or count (append)
        logic rd_parent;    // heap read at parent(pos)
        logic up_move;      // parent -> pos, pos <= parent
        logic place_e;      // e -> pos
        logic rd_root;      // heap read at 0
        logic take_root;    // record extracted entry, invalidate its map
        logic rd_last;      // heap read at count (after decrement)
        logic load_last;    // e <= read data, pos <= 0
        logic rd_child;     // heap read at child kid of pos
        logic kid_first;    // best <= read data (first child)
        logic kid_cmp;      // best <= read data if smaller
        logic down_move;    // best -> pos, pos <= best slot
        logic set_empty;
        logic done;         // pulse result
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       present;     // node in map and slot below count
        logic       full;
        logic       empty;
        logic       at_root;
        logic       parent_gt;   // item key < parent key
        logic       has_kids;    // first child below count
        logic       kid_more;    // child kid below count and not past the last one
        logic       best_lt;     // best child < e
        logic       count_one;   // count is 1 (before dec)
        logic       epoch_last;  // next clear wraps the epoch
        logic       sweep_last;  // sweep address at the last map entry
    } t_stat;

    function automatic logic key_less(input t_entry a, input t_entry b);
        return (a.distance < b.distance)
               || ((a.distance == b.distance) && (a.hops < b.hops));
    endfunction
endpackage
`default_nettype wire

### hdl/fahq_datapath.sv
// Datapath: heap memory, epoch-tagged position map, count and item registers
`default_nettype none
module fahq_datapath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [1:0]                 i_operation,
    input  wire logic [fahq_pkg::NODE_BITS-1:0] i_node_id,
    input  wire logic [31:0]                i_key_distance,
    input  wire logic [15:0]                i_key_hops,
    input  wire fahq_pkg::t_cmd             i_cmd,
    input  wire logic [fahq_pkg::KID_BITS-1:0] i_kid,
    output fahq_pkg::t_stat                 o_stat,
    output logic [fahq_pkg::NODE_BITS-1:0]  o_out_node,
    output logic [31:0]                     o_out_distance,
    output logic [15:0]                     o_out_hop_count,
    output logic                            o_status,
    output logic [10:0]                     o_entries_left
);
    import fahq_pkg::*;

    // Heap store and position map (map entry: epoch, valid, slot)
    localparam int MAP_W   = 8 + 1 + SLOT_BITS;
    localparam int FIRST_W = SLOT_BITS + ARITY_LOG + 1;
    t_entry r_heap [CAPACITY];
    logic [MAP_W-1:0] r_map [NODE_SPACE];

    t_entry               r_e, r_rd, r_best, r_top;
    logic [1:0]           r_op;
    logic [SLOT_BITS-1:0] r_pos, r_best_slot;
    logic [CNT_BITS-1:0]  r_count;
    logic [7:0]           r_epoch;
    logic [NODE_BITS-1:0] r_sweep_addr;
    logic                 r_map_v;
    logic [SLOT_BITS-1:0] r_map_slot;
    logic [7:0]           r_map_ep;
    logic                 r_status;
    logic [SLOT_BITS-1:0] r_child_q;

    logic [SLOT_BITS-1:0] w_parent, w_child, w_rd_addr, w_wr_addr;
    logic [FIRST_W-1:0]   w_child_w, w_first_w, w_count_w;
    logic                 w_we;
    t_entry               w_wdata;

    assign w_parent  = SLOT_BITS'((r_pos - 1'b1) >> ARITY_LOG);
    assign w_first_w = FIRST_W'({r_pos, {ARITY_LOG{1'b0}}}) + FIRST_W'(1);
    assign w_child_w = w_first_w + FIRST_W'(i_kid);
    assign w_child   = w_child_w[SLOT_BITS-1:0];
    assign w_count_w = FIRST_W'(r_count);

    // Heap read address
    always_comb begin
        priority if (i_cmd.rd_parent) w_rd_addr = w_parent;
        else if (i_cmd.rd_last)       w_rd_addr = r_count[SLOT_BITS-1:0];
        else if (i_cmd.rd_child)      w_rd_addr = w_child;
        else                          w_rd_addr = '0;
    end

    // Heap write port
    always_comb begin
        w_we = i_cmd.up_move | i_cmd.place_e | i_cmd.down_move;
        w_wr_addr = r_pos;
        priority if (i_cmd.up_move)   w_wdata = r_rd;
        else if (i_cmd.down_move)     w_wdata = r_best;
        else                          w_wdata = r_e;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_heap[w_wr_addr] <= w_wdata;
        r_rd <= r_heap[w_rd_addr];
    end

    // Position map: single port, writes on sweeps, moves, placements and root takes
    logic                 w_map_we;
    logic [NODE_BITS-1:0] w_map_addr;
    logic [MAP_W-1:0]     w_map_wdata;
    logic [MAP_W-1:0]     r_map_rd;
    always_comb begin
        w_map_we = 1'b0;
        w_map_addr = r_e.node;
        w_map_wdata = {r_epoch, 1'b1, r_pos};
        priority if (i_cmd.sweep) begin
            w_map_we = 1'b1; w_map_addr = r_sweep_addr;
            w_map_wdata = '0;
        end else if (i_cmd.up_move) begin
            w_map_we = 1'b1; w_map_addr = r_rd.node;
        end else if (i_cmd.down_move) begin
            w_map_we = 1'b1; w_map_addr = r_best.node;
        end else if (i_cmd.place_e) begin
            w_map_we = 1'b1;
        end else if (i_cmd.take_root) begin
            w_map_we = 1'b1; w_map_addr = r_rd.node;
            w_map_wdata = {r_epoch, 1'b0, r_pos};
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_map_we) r_map[w_map_addr] <= w_map_wdata;
        r_map_rd <= r_map[w_map_addr];
    end
    assign {r_map_ep, r_map_v, r_map_slot} = r_map_rd;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_epoch      <= '0;
            r_sweep_addr <= '0;
        end else begin
            if (i_cmd.clear_map)  r_epoch <= r_epoch + 8'd1;
            if (i_cmd.sweep)      r_sweep_addr <= r_sweep_addr + NODE_BITS'(1);
            if (i_cmd.set_count1) r_count <= CNT_BITS'(1);
            if (i_cmd.inc_count)  r_count <= r_count + CNT_BITS'(1);
            if (i_cmd.dec_count)  r_count <= r_count - CNT_BITS'(1);
        end
    end

    // Item and work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op     <= i_operation;
            r_e      <= '{node: i_node_id, distance: i_key_distance, hops: i_key_hops};
            r_pos    <= '0;
            r_top    <= '0;
            r_status <= 1'b0;
        end
        if (i_cmd.up_init_pos)
            r_pos <= o_stat.present ? r_map_slot : r_count[SLOT_BITS-1:0];
        if (i_cmd.up_move)   r_pos <= w_parent;
        if (i_cmd.take_root) r_top <= r_rd;
        if (i_cmd.load_last) begin
            r_e <= r_rd; r_pos <= '0;
        end
        if (i_cmd.kid_first || (i_cmd.kid_cmp && key_less(r_rd, r_best))) begin
            r_best      <= r_rd;
            r_best_slot <= r_child_q;
        end
        if (i_cmd.down_move) r_pos <= r_best_slot;
        if (i_cmd.set_empty) r_status <= 1'b1;
    end

    // Slot of the child whose data arrives this cycle
    always_ff @(posedge i_clk) r_child_q <= w_child;

    // Status to controller
    always_comb begin
        o_stat.op         = r_op;
        o_stat.present    = r_map_v && (r_map_ep == r_epoch)
                            && ({1'b0, r_map_slot} < r_count);
        o_stat.full       = (r_count == CNT_BITS'(CAPACITY));
        o_stat.empty      = (r_count == '0);
        o_stat.at_root    = (r_pos == '0);
        o_stat.parent_gt  = key_less(r_e, r_rd);
        o_stat.has_kids   = (w_first_w < w_count_w);
        // kid is the next child to read; zero again once all of them are read
        o_stat.kid_more   = (w_child_w < w_count_w) && (i_kid != '0);
        o_stat.best_lt    = key_less(r_best, r_e);
        o_stat.count_one  = (r_count == CNT_BITS'(1));
        o_stat.epoch_last = (r_epoch == 8'hFF);
        o_stat.sweep_last = (r_sweep_addr == '1);
    end

    assign o_out_node      = r_top.node;
    assign o_out_distance  = r_top.distance;
    assign o_out_hop_count = r_top.hops;
    assign o_status        = r_status;
    assign o_entries_left  = r_count;
endmodule
`default_nettype wire

### hdl/fahq_ctrl.sv
// Controller: sequences clear, sift-up and extract/sift-down
`default_nettype none
`include "assert_macros.svh"
module fahq_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    output logic                               o_done,
    input  wire fahq_pkg::t_stat               i_stat,
    output fahq_pkg::t_cmd                     o_cmd,
    output logic [fahq_pkg::KID_BITS-1:0]      o_kid
);
    import fahq_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DEC   = 5'd1;
    localparam logic [4:0] S_MAPW  = 5'd2;
    localparam logic [4:0] S_INS   = 5'd3;
    localparam logic [4:0] S_UPRD  = 5'd4;
    localparam logic [4:0] S_UPCMP = 5'd5;
    localparam logic [4:0] S_PLACE = 5'd6;
    localparam logic [4:0] S_ROOTW = 5'd7;
    localparam logic [4:0] S_ROOT  = 5'd8;
    localparam logic [4:0] S_LASTW = 5'd9;
    localparam logic [4:0] S_LAST  = 5'd10;
    localparam logic [4:0] S_KRD   = 5'd11;
    localparam logic [4:0] S_KCMP  = 5'd12;
    localparam logic [4:0] S_DONE  = 5'd13;
    localparam logic [4:0] S_KEND  = 5'd14;
    localparam logic [4:0] S_INIT  = 5'd15;
    localparam logic [4:0] S_SWEEP = 5'd16;

    logic [4:0]          r_state, n_state;
    logic [KID_BITS-1:0] r_kid, n_kid;
    logic                r_first, n_first;
    logic [2:0]          w_heap_wr;

    assign busy  = (r_state != S_IDLE);
    assign o_kid = r_kid;
    assign w_heap_wr = {o_cmd.up_move, o_cmd.place_e, o_cmd.down_move};

    always_comb begin
        n_state = r_state;
        n_kid   = r_kid;
        n_first = r_first;
        o_cmd   = '0;
        o_done  = 1'b0;
        unique case (r_state)
            // map sweep after reset
            S_INIT: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_stat.op)
                    OP_CLEAR: begin
                        o_cmd.clear_map = 1'b1;
                        o_cmd.set_count1 = 1'b1;
                        n_state = i_stat.epoch_last ? S_SWEEP : S_PLACE;
                    end
                    OP_INSERT: begin
                        o_cmd.rd_map = 1'b1;
                        n_state = S_MAPW;
                    end
                    OP_EXTRACT: begin
                        if (i_stat.empty) begin
                            o_cmd.set_empty = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_ROOTW;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            // epoch wrapped: old tags would match again, so clear the whole map
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) n_state = S_PLACE;
            end
            // map read data valid now
            S_MAPW: begin
                if (i_stat.present) begin
                    o_cmd.up_init_pos = 1'b1;
                    n_state = S_INS;
                end else if (!i_stat.full) begin
                    o_cmd.up_init_pos = 1'b1;
                    o_cmd.inc_count = 1'b1;
                    n_state = S_INS;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INS: begin
                if (i_stat.at_root) n_state = S_PLACE;
                else begin
                    o_cmd.rd_parent = 1'b1;
                    n_state = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (i_stat.parent_gt) begin
                    o_cmd.up_move = 1'b1;
                    n_state = S_UPRD;
                end else n_state = S_PLACE;
            end
            S_UPRD: n_state = S_INS;
            S_PLACE: begin
                o_cmd.place_e = 1'b1;
                n_state = S_DONE;
            end
            S_ROOTW: begin
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.take_root = 1'b1;
                o_cmd.dec_count = 1'b1;
                n_state = i_stat.count_one ? S_DONE : S_LASTW;
            end
            S_LASTW: begin
                o_cmd.rd_last = 1'b1;
                n_state = S_LAST;
            end
            S_LAST: begin
                o_cmd.load_last = 1'b1;
                n_state = S_KRD;
            end
            // r_kid is zero here: read the first child
            S_KRD: begin
                if (!i_stat.has_kids) n_state = S_PLACE;
                else begin
                    o_cmd.rd_child = 1'b1;
                    n_kid   = r_kid + KID_BITS'(1);
                    n_first = 1'b1;
                    n_state = S_KCMP;
                end
            end
            // data for the previous child arrives; read child r_kid if there is one
            S_KCMP: begin
                o_cmd.kid_first = r_first;
                o_cmd.kid_cmp   = !r_first;
                n_first = 1'b0;
                if (i_stat.kid_more) begin
                    n_kid = r_kid + KID_BITS'(1);
                    o_cmd.rd_child = 1'b1;
                end else begin
                    n_kid   = '0;
                    n_state = S_KEND;
                end
            end
            S_KEND: begin
                if (i_stat.best_lt) begin
                    o_cmd.down_move = 1'b1;
                    n_state = S_KRD;
                end else n_state = S_PLACE;
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                o_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_kid   <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kid   <= n_kid;
            r_first <= n_first;
        end
    end

    `ASSERT_NEXT(a_done_to_idle, i_clk, i_rst_n, o_done, !busy, "done not followed by idle")
    `ASSERT_IMPL(a_start_idle, i_clk, i_rst_n, o_cmd.latch_in, !busy, "latch while busy")
    `ASSERT_IMPL(a_one_write, i_clk, i_rst_n, 1'b1, $onehot0(w_heap_wr), "two heap writes")
endmodule
`default_nettype wire

### hdl/four_ary_heap_decrease_key_queue.sv
// Top level: 4-ary min-heap priority queue with decrease-key
//  channel | direction | handshake              | fields
//  command | in        | start high, busy low   | operation, node_id, key_distance, key_hops
//  result  | out       | o_done strobe, 1 cycle | out_node, out_distance, out_hop_count,
//          |           |                        | status, entries_left
// One transaction at a time; the next one can be accepted the cycle after the strobe.
// A clear also sweeps the whole map on every 256th clear, when the epoch wraps. Insert
// sifts up level by level; extract sifts down level by level, reading the children of
// each level one after another. The heap memory serves one heap read per cycle.
// Synchronous active-low reset empties the queue, then a sweep of all 1024 map entries holds busy.
// The receiver cannot stall; the result is held until the next command is accepted.
`default_nettype none
module four_ary_heap_decrease_key_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_operation,
    input  wire logic [9:0]  i_node_id,
    input  wire logic [31:0] i_key_distance,
    input  wire logic [15:0] i_key_hops,
    output logic             o_done,
    output logic [9:0]       o_out_node,
    output logic [31:0]      o_out_distance,
    output logic [15:0]      o_out_hop_count,
    output logic             o_status,
    output logic [10:0]      o_entries_left
);
    import fahq_pkg::*;

    t_cmd                w_cmd;
    t_stat               w_stat;
    logic [KID_BITS-1:0] w_kid;

    fahq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .busy, .o_done,
        .i_stat(w_stat), .o_cmd(w_cmd), .o_kid(w_kid)
    );

    fahq_datapath u_dp (
        .i_clk, .i_rst_n, .i_operation, .i_node_id, .i_key_distance, .i_key_hops,
        .i_cmd(w_cmd), .i_kid(w_kid), .o_stat(w_stat),
        .o_out_node, .o_out_distance, .o_out_hop_count, .o_status, .o_entries_left
    );
endmodule
`default_nettype wire
